@@ sv/i2a_pkg.sv @@
// Shared types, constants and helpers for the integer to ASCII radix converter.
package i2a_pkg;

  // Field widths and derived counter widths.
  localparam int VALUE_BITS = 32;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int IDX_W      = $clog2(VALUE_BITS);
  localparam int NDIG_W     = $clog2(VALUE_BITS + 1);
  localparam int RADIX_W    = 6;
  localparam int CAP_W      = 8;
  localparam int CHAR_W     = 8;

  // Radix limits and character codes.
  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0]  CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 8'h41;

  // Kind of output word the controller asks for.
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_ERROR,
    EMIT_MINUS,
    EMIT_DIGIT,
    EMIT_TERM
  } emit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  div_step;
    logic  push;
    emit_t emit;
  } i2a_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic quot_zero;
    logic stack_full;
    logic too_big;
    logic negative;
    logic one_left;
  } i2a_sts_t;

  // Map a digit value 0..35 onto its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = CHAR_W'(d);
    if (d < DEC_DIGITS) begin
      return CHAR_ZERO + dx;
    end
    return CHAR_A + dx - CHAR_W'(DEC_DIGITS);
  endfunction

endpackage

@@ sv/i2a_datapath.sv @@
// Datapath: magnitude divider, digit stack, length check and output word register.
module i2a_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  i2a_pkg::i2a_cmd_t             cmd,
  output i2a_pkg::i2a_sts_t             sts,
  input  logic [i2a_pkg::VALUE_BITS-1:0] value,
  input  logic [i2a_pkg::RADIX_W-1:0]    radix,
  input  logic [i2a_pkg::CAP_W-1:0]      capacity,
  output logic                          strobe,
  output logic [i2a_pkg::CHAR_W-1:0]     char_code,
  output logic                          status,
  output logic                          last
);
  import i2a_pkg::*;

  logic [VALUE_BITS-1:0] mag;
  logic [VALUE_BITS-1:0] mag_next;
  logic [RADIX_W-1:0]    rem;
  logic [RADIX_W-1:0]    rem_next;
  logic [RADIX_W:0]      trial;
  logic                  ge;
  logic [RADIX_W-1:0]    radix_r;
  logic [RADIX_W-1:0]    radix_sat;
  logic [CAP_W-1:0]      cap_r;
  logic                  neg;
  logic [NDIG_W-1:0]     ndig;
  logic [NDIG_W-1:0]     ndig_dec;
  logic [CAP_W-1:0]      count;
  logic [VALUE_BITS-1:0] value_abs;
  logic [RADIX_W-1:0]    stack [VALUE_BITS];

  // Saturate the radix and take the magnitude as an unsigned number.
  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = radix;
    end
    value_abs = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
  end

  // One restoring division step: shift in the next magnitude bit.
  always_comb begin
    trial    = {rem, mag[VALUE_BITS-1]};
    ge       = (trial >= {1'b0, radix_r});
    rem_next = ge ? RADIX_W'(trial - {1'b0, radix_r}) : trial[RADIX_W-1:0];
    mag_next = {mag[VALUE_BITS-2:0], ge};
  end

  // Status toward the controller.
  always_comb begin
    ndig_dec       = ndig - 1'b1;
    count          = CAP_W'(ndig) + CAP_W'(1) + CAP_W'(neg);
    sts.quot_zero  = (mag_next == '0);
    sts.stack_full = (ndig == NDIG_W'(VALUE_BITS - 1));
    sts.too_big    = (count > cap_r);
    sts.negative   = neg;
    sts.one_left   = (ndig == NDIG_W'(1));
  end

  // Operand registers, divider state and digit count.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag     <= value_abs;
      rem     <= '0;
      ndig    <= '0;
      neg     <= value[VALUE_BITS-1];
      radix_r <= radix_sat;
      cap_r   <= capacity;
    end else if (cmd.div_step) begin
      mag <= mag_next;
      if (cmd.push) begin
        rem                      <= '0;
        stack[ndig[IDX_W-1:0]]   <= rem_next;
        ndig                     <= ndig + 1'b1;
      end else begin
        rem <= rem_next;
      end
    end else if (cmd.emit == EMIT_DIGIT) begin
      ndig <= ndig_dec;
    end
  end

  // Output word register; the stack is read here, top first.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (cmd.emit != EMIT_NONE);
    end
    unique case (cmd.emit)
      EMIT_ERROR: begin
        char_code <= CHAR_NUL;
        status    <= 1'b1;
        last      <= 1'b1;
      end
      EMIT_MINUS: begin
        char_code <= CHAR_MINUS;
        status    <= 1'b0;
        last      <= 1'b0;
      end
      EMIT_DIGIT: begin
        char_code <= digit_char(stack[ndig_dec[IDX_W-1:0]]);
        status    <= 1'b0;
        last      <= 1'b0;
      end
      EMIT_TERM: begin
        char_code <= CHAR_NUL;
        status    <= 1'b0;
        last      <= 1'b1;
      end
      default: begin
        char_code <= CHAR_NUL;
        status    <= 1'b0;
        last      <= 1'b0;
      end
    endcase
  end

endmodule

@@ sv/i2a_ctrl.sv @@
// Controller: sequences division, length check and character output.
module i2a_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output i2a_pkg::i2a_cmd_t cmd,
  input  i2a_pkg::i2a_sts_t sts
);
  import i2a_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_DIGITS,
    S_TERM
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] bit_cnt;
  logic [CNT_W-1:0] bit_cnt_next;
  logic             last_bit;

  // Next state and commands.
  always_comb begin
    state_next   = state;
    bit_cnt_next = bit_cnt;
    last_bit     = (bit_cnt == CNT_W'(VALUE_BITS - 1));
    cmd.load     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.push     = 1'b0;
    cmd.emit     = EMIT_NONE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load     = 1'b1;
          bit_cnt_next = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        bit_cnt_next = bit_cnt + 1'b1;
        if (last_bit) begin
          cmd.push     = 1'b1;
          bit_cnt_next = '0;
          if (sts.quot_zero || sts.stack_full) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.too_big) begin
          cmd.emit   = EMIT_ERROR;
          state_next = S_IDLE;
        end else begin
          if (sts.negative) begin
            cmd.emit = EMIT_MINUS;
          end
          state_next = S_DIGITS;
        end
      end
      S_DIGITS: begin
        cmd.emit = EMIT_DIGIT;
        if (sts.one_left) begin
          state_next = S_TERM;
        end
      end
      S_TERM: begin
        cmd.emit   = EMIT_TERM;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    busy = (state != S_IDLE);
  end

  // State and bit counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_cnt <= '0;
    end else begin
      state   <= state_next;
      bit_cnt <= bit_cnt_next;
    end
  end

endmodule

@@ sv/int_to_ascii_radix_top.sv @@
// Integer to ASCII radix converter: top level joining controller and datapath.
// Each digit comes from the bit-serial restoring divider, which steps through all VALUE_BITS (32)
// magnitude bits; a check state then tests the length and issues the sign or error word, then
// one word per cycle follows. Synchronous active-high reset returns to idle with no word pending;
// results cannot stall, and a new start is taken only while idle.
module int_to_ascii_radix_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [i2a_pkg::VALUE_BITS-1:0] value,
  input  logic [i2a_pkg::RADIX_W-1:0]    radix,
  input  logic [i2a_pkg::CAP_W-1:0]      capacity,
  output logic                          strobe,
  output logic [i2a_pkg::CHAR_W-1:0]     char_code,
  output logic                          status,
  output logic                          last
);
  import i2a_pkg::*;

  i2a_cmd_t cmd;
  i2a_sts_t sts;

  // Sequencer.
  i2a_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Arithmetic, digit storage and output word.
  i2a_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .radix     (radix),
    .capacity  (capacity),
    .strobe    (strobe),
    .char_code (char_code),
    .status    (status),
    .last      (last)
  );

  // A word only comes out of a conversion in progress.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("word issued while idle");

  // An error word is always the only and final word.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && status) |-> last)
    else $error("error word without last");

  // The final word is never followed directly by another word.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("word right after final word");

  // Work starts only on an accepted command.
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without start");

endmodule
